>>> src/e2f_pkg.sv
// Package: format codes, shared types and conversion helpers for the element converter
package e2f_pkg;

    typedef enum logic [2:0] {
        FMT_F32   = 3'd0,
        FMT_F16   = 3'd1,
        FMT_BF16  = 3'd2,
        FMT_I8    = 3'd3,
        FMT_U8    = 3'd4,
        FMT_I16   = 3'd5,
        FMT_I32   = 3'd6,
        FMT_UNSUP = 3'd7
    } elem_fmt_t;

    localparam logic [7:0] F16_REBIAS    = 8'd112;
    localparam logic [4:0] F16_EXP_ONES  = 5'h1F;
    localparam logic [7:0] F32_EXP_ONES  = 8'hFF;

    typedef struct packed {
        logic [31:0] raw_bits;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        unsupported;
        logic        last_element;
    } out_item_t;

    // Leading-one position of a nonzero 32-bit value (priority encoder).
    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> src/e2f_input_stage.sv
// Input register: accept a transaction and hold it until the converter stage advances
`default_nettype none
module e2f_input_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire e2f_pkg::in_item_t s_item,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output e2f_pkg::in_item_t      q_item
);
    import e2f_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end
endmodule
`default_nettype wire

>>> src/e2f_convert.sv
// Combinational conversion of one element to a binary32 bit pattern
`default_nettype none
module e2f_convert (
    input  wire logic              [2:0] element_format,
    input  wire e2f_pkg::in_item_t       item,
    output e2f_pkg::out_item_t           result
);
    import e2f_pkg::*;

    logic [31:0] raw;
    logic [31:0] mag;
    logic        neg;
    logic        is_int;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [23:0] keep;
    logic        rnd;
    logic [24:0] keep_r;
    logic [31:0] int_bits;
    logic [31:0] h_bits;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [3:0]  h_lz;
    logic [9:0]  h_nman;
    logic [31:0] bits;
    logic        bad;

    assign raw = item.raw_bits;

    always_comb begin
        neg    = 1'b0;
        mag    = 32'd0;
        is_int = 1'b1;
        unique case (elem_fmt_t'(element_format))
            FMT_I8: begin
                neg = raw[7];
                mag = raw[7] ? 32'(9'h100 - {1'b0, raw[7:0]}) : {24'd0, raw[7:0]};
            end
            FMT_U8:  mag = {24'd0, raw[7:0]};
            FMT_I16: begin
                neg = raw[15];
                mag = raw[15] ? 32'(17'h10000 - {1'b0, raw[15:0]}) : {16'd0, raw[15:0]};
            end
            FMT_I32: begin
                neg = raw[31];
                mag = raw[31] ? (32'd0 - raw) : raw;
            end
            default: is_int = 1'b0;
        endcase
    end

    // Normalize so the leading one lands at bit 31, then round to 24 bits.
    always_comb begin
        p        = msb_pos(mag);
        norm     = mag << (5'd31 - p);
        keep     = norm[31:8];
        rnd      = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
        keep_r   = {1'b0, keep} + {24'd0, rnd};
        int_bits = {neg, 31'd0} + ({(8'd126 + {3'd0, p}), 23'd0} + {7'd0, keep_r});
        if (mag == 32'd0) begin
            int_bits = {neg, 31'd0};
        end
    end

    always_comb begin
        h_exp  = raw[14:10];
        h_man  = raw[9:0];
        h_lz   = 4'(5'd9 - msb_pos({22'd0, h_man}));
        h_nman = 10'(h_man << (h_lz + 4'd1));
        if (h_exp == 5'd0) begin
            if (h_man == 10'd0) begin
                h_bits = {raw[15], 31'd0};
            end else begin
                h_bits = {raw[15], 8'(F16_REBIAS - {4'd0, h_lz}), h_nman, 13'd0};
            end
        end else if (h_exp == F16_EXP_ONES) begin
            h_bits = {raw[15], F32_EXP_ONES, h_man, 13'd0};
        end else begin
            h_bits = {raw[15], F16_REBIAS + {3'd0, h_exp}, h_man, 13'd0};
        end
    end

    always_comb begin
        bad  = 1'b0;
        bits = int_bits;
        unique case (elem_fmt_t'(element_format))
            FMT_F32:   bits = raw;
            FMT_F16:   bits = h_bits;
            FMT_BF16:  bits = {raw[15:0], 16'd0};
            FMT_UNSUP: begin
                bits = 32'd0;
                bad  = 1'b1;
            end
            default:   bits = is_int ? int_bits : 32'd0;
        endcase
    end

    assign result.float_bits   = bits;
    assign result.unsupported  = bad;
    assign result.last_element = item.last_element;
endmodule
`default_nettype wire

>>> src/e2f_output_stage.sv
// Result register: hold a converted transaction until the consumer takes it
`default_nettype none
module e2f_output_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               d_valid,
    output logic                    d_ready,
    input  wire e2f_pkg::out_item_t d_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output e2f_pkg::out_item_t      m_item
);
    import e2f_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;

    assign d_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (d_ready) begin
            valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && d_valid) begin
            item_reg <= d_item;
        end
    end
endmodule
`default_nettype wire

>>> src/element_to_fp32_converter.sv
// Top level of the element to binary32 converter
//   channel   direction  handshake         payload
//   s_        in         s_valid/s_ready   s_raw_bits[31:0], s_last_element
//   m_        out        m_valid/m_ready   m_float_bits[31:0], m_unsupported, m_last_element_out
//   cfg       in         cfg_we            cfg_wdata[2:0] (element format)
// One transaction per cycle while m_ready is high; stages: input register, result register.
// The conversion logic between the two registers sets the clock limit.
// Synchronous active-low reset empties both stages and sets the format to binary32.
// A stall on m_ready fills the result register, then the input register, then drops s_ready.
`default_nettype none
module element_to_fp32_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_raw_bits,
    input  wire logic        s_last_element,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_float_bits,
    output logic             m_unsupported,
    output logic             m_last_element_out
);
    import e2f_pkg::*;

    logic [2:0] format_reg;
    in_item_t   s_item;
    in_item_t   q_item;
    logic       q_valid;
    logic       q_ready;
    out_item_t  c_item;
    out_item_t  m_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FMT_F32;
        end else if (cfg_we) begin
            format_reg <= cfg_wdata;
        end
    end

    assign s_item.raw_bits     = s_raw_bits;
    assign s_item.last_element = s_last_element;

    e2f_input_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    e2f_convert u_cvt (
        .element_format (format_reg),
        .item           (q_item),
        .result         (c_item)
    );

    e2f_output_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .d_valid (q_valid),
        .d_ready (q_ready),
        .d_item  (c_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign m_float_bits       = m_item.float_bits;
    assign m_unsupported      = m_item.unsupported;
    assign m_last_element_out = m_item.last_element;
endmodule
`default_nettype wire

>>> src/e2f_checker.sv
// Port-level assertions for the element converter, bound to the top level
`default_nettype none
module e2f_assertions (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_float_bits,
    input wire logic        m_unsupported
);
    a_unsup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unsupported |-> m_float_bits == 32'd0)
        else $error("unsupported result carries nonzero bits");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_float_bits))
        else $error("stalled result changed");
endmodule
`default_nettype wire

bind element_to_fp32_converter e2f_assertions u_e2f_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_float_bits  (m_float_bits),
    .m_unsupported (m_unsupported)
);

>>> dv/e2f_checker.sv
// Checker: watches both channels of the element converter, predicts results and compares them
module e2f_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_raw_bits,
    input  wire logic        s_last_element,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_float_bits,
    input  wire logic        m_unsupported,
    input  wire logic        m_last_element_out,
    output int               fail_count,
    output int               pending_count
);
    import e2f_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    elem_fmt_t fmt_shadow;
    out_item_t expected_conversions[$];

    function automatic logic [31:0] signed_mag_to_fp32(logic [31:0] sgn, logic [31:0] mag);
        int unsigned p;
        int unsigned sh;
        logic [31:0] keep;
        logic [31:0] rem;
        logic [31:0] half;
        p = 0;
        if (mag == 0) return sgn;
        for (int i = 0; i < 32; i++) if (mag[i]) p = i;
        if (p <= 23) begin
            keep = mag << (23 - p);
        end else begin
            sh = p - 23;
            rem = mag & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            keep = mag >> sh;
            if (rem > half || (rem == half && keep[0])) keep = keep + 1;
        end
        return sgn | (((32'd126 + p) << 23) + keep);
    endfunction

    function automatic logic [31:0] half_to_fp32(logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0] ex;
        logic [9:0] man;
        logic [10:0] norm;
        int shifts;
        sgn = {h[15], 31'd0};
        ex = h[14:10];
        man = h[9:0];
        shifts = 0;
        if (ex == 0) begin
            if (man == 0) return sgn;
            norm = {1'b0, man};
            while (!norm[10]) begin
                norm = norm << 1;
                shifts++;
            end
            return sgn | (32'(113 - shifts) << 23) | (32'(norm[9:0]) << 13);
        end
        if (ex == 5'h1F) return sgn | 32'h7F80_0000 | (32'(man) << 13);
        return sgn | ((32'(ex) + 32'd112) << 23) | (32'(man) << 13);
    endfunction

    function automatic out_item_t convert_element(elem_fmt_t f, logic [31:0] raw, logic lst);
        out_item_t r;
        r.float_bits = 0;
        r.unsupported = 0;
        r.last_element = lst;
        case (f)
            FMT_F32:  r.float_bits = raw;
            FMT_F16:  r.float_bits = half_to_fp32(raw[15:0]);
            FMT_BF16: r.float_bits = {raw[15:0], 16'd0};
            FMT_I8:   r.float_bits = raw[7] ? signed_mag_to_fp32(32'h8000_0000, 32'h100 - raw[7:0])
                                            : signed_mag_to_fp32(0, {24'd0, raw[7:0]});
            FMT_U8:   r.float_bits = signed_mag_to_fp32(0, {24'd0, raw[7:0]});
            FMT_I16:  r.float_bits = raw[15]
                                     ? signed_mag_to_fp32(32'h8000_0000, 32'h10000 - raw[15:0])
                                     : signed_mag_to_fp32(0, {16'd0, raw[15:0]});
            FMT_I32:  r.float_bits = raw[31] ? signed_mag_to_fp32(32'h8000_0000, 0 - raw)
                                             : signed_mag_to_fp32(0, raw);
            default:  r.unsupported = 1;
        endcase
        return r;
    endfunction

    assign pending_count = expected_conversions.size();

    always @(posedge aclk) begin
        out_item_t exp_item;
        if (!aresetn) begin
            fmt_shadow <= FMT_F32;
            expected_conversions.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) fmt_shadow <= elem_fmt_t'(cfg_wdata);
            if (s_valid && s_ready)
                expected_conversions.push_back(
                    convert_element(fmt_shadow, s_raw_bits, s_last_element));
            if (m_valid && m_ready) begin
                if (expected_conversions.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h %b %b", $time,
                             m_float_bits, m_unsupported, m_last_element_out);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = expected_conversions.pop_front();
                    if (exp_item.float_bits !== m_float_bits
                        || exp_item.unsupported !== m_unsupported
                        || exp_item.last_element !== m_last_element_out) begin
                        $display("%0t: mismatch, expected %h %b %b, actual %h %b %b", $time,
                                 exp_item.float_bits, exp_item.unsupported,
                                 exp_item.last_element, m_float_bits, m_unsupported,
                                 m_last_element_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> dv/tb_top.sv
// Testbench top: stimulus, configuration phases and verdict for the element converter
module tb_top;
    import e2f_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_raw_bits = '0;
    logic        s_last_element = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_float_bits;
    logic        m_unsupported;
    logic        m_last_element_out;
    int          fail_count;
    int          pending_count;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    element_to_fp32_converter i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .s_valid, .s_ready, .s_raw_bits,
        .s_last_element, .m_valid, .m_ready, .m_float_bits, .m_unsupported,
        .m_last_element_out
    );

    e2f_checker i_checker (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .s_valid, .s_ready, .s_raw_bits,
        .s_last_element, .m_valid, .m_ready, .m_float_bits, .m_unsupported,
        .m_last_element_out, .fail_count, .pending_count
    );

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random stalls on the result side, with a stall-free stretch
    always @(posedge aclk) begin
        if (!aresetn || ($time > 100000 && $time < 140000)) begin
            m_ready <= 1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    task automatic send_element(logic [31:0] raw, logic lst, bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_raw_bits <= raw;
        s_last_element <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid and hold until every expected result has come
    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic drain_and_set_format(elem_fmt_t f);
        wait_idle();
        repeat (4) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= f;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] random_raw(elem_fmt_t f);
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0: r[14:10] = 5'h00;
            1: r[14:10] = 5'h1F;
            2: r[30:23] = 8'hFF;
            3: r = r >> $urandom_range(0, 31);
            default: ;
        endcase
        if (f == FMT_I32 && $urandom_range(0, 3) == 0) r[6:0] = 7'h40;
        return r;
    endfunction

    localparam logic [31:0] DIRECTED_RAW [20] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000,
        32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01, 32'h0000_0001, 32'h0000_83FF,
        32'h0000_0080, 32'h0000_007F, 32'h7FC0_0001, 32'hFFFF_0001, 32'h0100_0001,
        32'h0100_0003, 32'h0000_0400, 32'h8000_0001, 32'h0000_0200, 32'hABCD_1234
    };

    initial begin
        elem_fmt_t f;
        elem_fmt_t sweep_fmt [10];
        int n;
        sweep_fmt = '{FMT_F32, FMT_F16, FMT_BF16, FMT_I8, FMT_U8, FMT_I16, FMT_I32,
                      FMT_UNSUP, FMT_I32, FMT_F16};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int k = 0; k < 10; k++) begin
            f = sweep_fmt[k];
            if (k != 0) drain_and_set_format(f);
            foreach (DIRECTED_RAW[j]) send_element(DIRECTED_RAW[j], j[0], 0);
            n = (f == FMT_F16 || f == FMT_I32) ? 170 : 120;
            for (int j = 0; j < n; j++) begin
                if (j == n / 2) begin
                    wait_idle();
                end
                send_element(random_raw(f), $urandom_range(0, 1), (k == 4));
            end
        end
        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
